[rtl/aes_pkg.sv]
package aes_pkg;

    typedef logic [127:0] blk_t;

    localparam int NumRounds = 10;
    localparam logic CmdEncrypt = 1'b0;
    localparam logic CmdDecrypt = 1'b1;
    localparam logic [3:0] RegKeyHigh = 4'd0;
    localparam logic [3:0] RegKeyLow  = 4'd8;

    localparam logic [7:0] FWD_BOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] REV_BOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    // byte k of the block sits at bits 127-8k
    function automatic logic [7:0] get_byte(input blk_t s, input int k);
        get_byte = s[127 - 8 * k -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic blk_t sub_fwd(input blk_t s);
        blk_t o;
        for (int k = 0; k < 16; k++)
        begin
            o[127 - 8 * k -: 8] = FWD_BOX[get_byte(s, k)];
        end
        sub_fwd = o;
    endfunction

    function automatic blk_t sub_rev(input blk_t s);
        blk_t o;
        for (int k = 0; k < 16; k++)
        begin
            o[127 - 8 * k -: 8] = REV_BOX[get_byte(s, k)];
        end
        sub_rev = o;
    endfunction

    function automatic blk_t shift_fwd(input blk_t s);
        blk_t o;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o[127 - 8 * (c * 4 + r) -: 8] = get_byte(s, ((c + r) % 4) * 4 + r);
            end
        end
        shift_fwd = o;
    endfunction

    function automatic blk_t shift_rev(input blk_t s);
        blk_t o;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o[127 - 8 * (((c + r) % 4) * 4 + r) -: 8] = get_byte(s, c * 4 + r);
            end
        end
        shift_rev = o;
    endfunction

    function automatic blk_t mix_fwd(input blk_t s);
        blk_t o;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, c * 4);
            a1 = get_byte(s, c * 4 + 1);
            a2 = get_byte(s, c * 4 + 2);
            a3 = get_byte(s, c * 4 + 3);
            o[127 - 8 * (c * 4) -: 8]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            o[127 - 8 * (c * 4 + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            o[127 - 8 * (c * 4 + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            o[127 - 8 * (c * 4 + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        mix_fwd = o;
    endfunction

    // inverse mix: pre-multiply by {05,00,04,00} then forward mix
    function automatic blk_t mix_rev(input blk_t s);
        blk_t o;
        logic [7:0] u, v;
        for (int c = 0; c < 4; c++)
        begin
            u = xtime(xtime(get_byte(s, c * 4) ^ get_byte(s, c * 4 + 2)));
            v = xtime(xtime(get_byte(s, c * 4 + 1) ^ get_byte(s, c * 4 + 3)));
            o[127 - 8 * (c * 4) -: 8]     = get_byte(s, c * 4) ^ u;
            o[127 - 8 * (c * 4 + 1) -: 8] = get_byte(s, c * 4 + 1) ^ v;
            o[127 - 8 * (c * 4 + 2) -: 8] = get_byte(s, c * 4 + 2) ^ u;
            o[127 - 8 * (c * 4 + 3) -: 8] = get_byte(s, c * 4 + 3) ^ v;
        end
        mix_rev = mix_fwd(o);
    endfunction

    function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
        logic [31:0] t;
        blk_t o;
        t = {FWD_BOX[k[23:16]] ^ rc, FWD_BOX[k[15:8]], FWD_BOX[k[7:0]], FWD_BOX[k[31:24]]};
        o[127:96] = k[127:96] ^ t;
        o[95:64]  = k[95:64] ^ o[127:96];
        o[63:32]  = k[63:32] ^ o[95:64];
        o[31:0]   = k[31:0] ^ o[63:32];
        next_key = o;
    endfunction

    typedef struct packed {
        logic valid;
        logic cmd;
    } ctl_t;

endpackage

[rtl/aes_key_sched.sv]
module aes_key_sched
    import aes_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  blk_t key,
    output blk_t round_key [0:aes_pkg::NumRounds],
    output logic busy
);

    // One expansion step per stage, so a new key ripples through the rk_reg stages to the
    // last round key. Hold busy until then.
    blk_t rk_next [1:NumRounds];
    blk_t rk_reg  [1:NumRounds];
    logic [3:0] settle_next, settle_reg;

    always_comb
    begin
        rk_next[1] = next_key(key, RCON[0]);
        for (int r = 2; r <= NumRounds; r++)
        begin
            rk_next[r] = next_key(rk_reg[r - 1], RCON[r - 1]);
        end
    end

    always_ff @(posedge clk)
    begin
        rk_reg <= rk_next;
    end

    always_comb
    begin
        round_key[0] = key;
        for (int r = 1; r <= NumRounds; r++)
        begin
            round_key[r] = rk_reg[r];
        end
    end

    always_comb
    begin
        if (load)
        begin
            settle_next = 4'(NumRounds);
        end
        else if (settle_reg != 4'd0)
        begin
            settle_next = settle_reg - 4'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= 4'(NumRounds);
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    assign busy = (settle_reg != 4'd0);

endmodule

[rtl/aes_round.sv]
module aes_round
    import aes_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  ctl_t ctl_in,
    input  blk_t state_in,
    input  blk_t enc_key,
    input  blk_t dec_key,
    input  logic last,
    output ctl_t ctl_out,
    output blk_t state_out
);

    // encrypt: sub, shift, mix (not last), add key
    // decrypt: shift^-1, sub^-1, add key, mix^-1 (not last)
    blk_t enc_v, dec_v, state_next, state_reg;
    ctl_t ctl_reg;

    always_comb
    begin
        enc_v = shift_fwd(sub_fwd(state_in));
        if (!last)
        begin
            enc_v = mix_fwd(enc_v);
        end
        enc_v = enc_v ^ enc_key;
        dec_v = sub_rev(shift_rev(state_in)) ^ dec_key;
        if (!last)
        begin
            dec_v = mix_rev(dec_v);
        end
        state_next = (ctl_in.cmd == CmdDecrypt) ? dec_v : enc_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign state_out = state_reg;

endmodule

[rtl/aes128_block_cipher.sv]
// AES-128 encrypt/decrypt pipeline, one block per cycle when not stalled. There are
// eleven register stages: the initial key add, then one stage per round; the last
// round stage drives the result. A held output beat freezes the whole pipe and stalls
// the input. The round keys are rebuilt one round per cycle from key_high/key_low;
// after reset and after every key write the input stalls while they settle. Write the
// keys only while the pipe is empty.
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);

    logic [63:0] key_high_reg, key_low_reg;
    blk_t round_key [0:NumRounds];
    ctl_t ctl   [0:NumRounds];
    blk_t state [0:NumRounds];
    ctl_t ctl0_reg;
    blk_t state0_reg;
    logic advance;
    logic key_load;
    logic key_busy;

    assign pready   = 1'b1;
    assign key_load = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (key_load)
        begin
            unique case (paddr)
                RegKeyHigh: key_high_reg <= pwdata;
                RegKeyLow:  key_low_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            RegKeyHigh: prdata = key_high_reg;
            RegKeyLow:  prdata = key_low_reg;
            default:    prdata = '0;
        endcase
    end

    aes_key_sched u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (key_load),
        .key       ({key_high_reg, key_low_reg}),
        .round_key (round_key),
        .busy      (key_busy)
    );

    // whole pipe moves unless the output beat is held
    assign advance  = !(ctl[NumRounds].valid && out_stall);
    assign in_stall = !advance || key_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (advance)
        begin
            ctl0_reg <= '{valid: in_valid && !key_busy, cmd: command};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state0_reg <= {block_high, block_low} ^
                ((command == CmdDecrypt) ? round_key[NumRounds] : round_key[0]);
        end
    end

    assign ctl[0]   = ctl0_reg;
    assign state[0] = state0_reg;

    for (genvar r = 1; r <= NumRounds; r++)
    begin : g_round
        aes_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .ctl_in    (ctl[r - 1]),
            .state_in  (state[r - 1]),
            .enc_key   (round_key[r]),
            .dec_key   (round_key[NumRounds - r]),
            .last      (r == NumRounds),
            .ctl_out   (ctl[r]),
            .state_out (state[r])
        );
    end

    assign out_valid   = ctl[NumRounds].valid;
    assign result_high = state[NumRounds][127:64];
    assign result_low  = state[NumRounds][63:0];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_high) && $stable(result_low))
        else $error("held result changed");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall) || key_busy)
        else $error("pipe stalled without output back-pressure");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> ctl[0].valid == $past(in_valid))
        else $error("input beat lost or invented");

endmodule
